### rtl/sbfd_pkg.sv
// ----------------------------------------------------------------------------
// sbfd_pkg
// shared constants and types of the s.bus frame decoder
// ----------------------------------------------------------------------------
package sbfd_pkg;

  localparam int CHANNELS_DEF = 16;

  localparam int FRAME_LEN  = 25;
  localparam int IDX_BITS   = 5;
  localparam int VAL_BITS   = 11;
  localparam int ACC_BITS   = 18;   // up to 10 leftover bits plus one byte
  localparam int CNT_BITS   = 5;

  localparam logic [7:0] START_BYTE = 8'h0F;
  localparam logic [7:0] END_BYTE   = 8'h00;

  localparam logic [IDX_BITS-1:0] FIRST_DATA_IDX = 5'd1;
  localparam logic [IDX_BITS-1:0] FLAG_IDX       = 5'd23;
  localparam logic [IDX_BITS-1:0] END_IDX        = 5'd24;

  localparam int LOST_BIT     = 2;
  localparam int FAILSAFE_BIT = 3;

  localparam int SUBST_CHANNELS = 4;
  localparam logic [VAL_BITS-1:0] MIDDLE_RESET = 11'd1024;

  typedef enum logic [1:0] {
    LINK_OK       = 2'd0,
    LINK_LOST     = 2'd1,
    LINK_FAILSAFE = 2'd2
  } link_status_t;

  typedef enum logic [1:0] {
    S_RX,      // collecting frame bytes
    S_FETCH,   // read of the next packed byte issued
    S_MERGE,   // read data merged into the bit accumulator
    S_EMIT     // one channel moved to the output register
  } state_t;

endpackage

### rtl/sbus_frame_decoder.sv
// ----------------------------------------------------------------------------
// sbus_frame_decoder
// receives s.bus frame bytes and emits one word per decoded channel
// ----------------------------------------------------------------------------
// unpack: after the end byte is taken, each packed byte is read from the frame
//   store (registered read) and then merged; a channel word is loaded once the
//   accumulator holds enough bits (22 packed bytes for 16 channels)
// throughput: one byte a cycle while collecting; no byte is taken while the
//   frame store is being unpacked
// reset: waits for a start byte, middle value back to 1024, output empty
module sbus_frame_decoder
  #(parameter int CHANNELS = sbfd_pkg::CHANNELS_DEF)
  (input  logic       clk,
   input  logic       rst,
   // configuration
   input  logic       cfg_we,
   input  logic [10:0] cfg_wdata,
   // byte input
   input  logic       in_valid,
   output logic       in_stall,
   input  logic [7:0] rx_byte,
   // channel output
   output logic       out_valid,
   input  logic       out_stall,
   output logic [3:0] channel,
   output logic [10:0] value,
   output logic [1:0] link_status,
   output logic       last);

  import sbfd_pkg::*;

  localparam logic [3:0] LastCh = 4'(CHANNELS - 1);
  localparam logic [CNT_BITS-1:0] MergeNeed = CNT_BITS'(VAL_BITS - 8);
  localparam logic [CNT_BITS-1:0] ValBits   = CNT_BITS'(VAL_BITS);
  localparam logic [3:0] SubstCh = 4'(SUBST_CHANNELS);

  // frame store: one write port for receive, one read port for unpack
  logic [7:0]          frame_store [FRAME_LEN];
  logic [IDX_BITS-1:0] wr_addr;
  logic                mem_we;
  logic [IDX_BITS-1:0] rd_addr;
  logic [7:0]          rd_data;

  // receive side
  logic                in_frame;
  logic [IDX_BITS-1:0] byte_index;
  link_status_t        status;
  logic [VAL_BITS-1:0] middle_value;

  // unpack side
  state_t              state, state_next;
  logic [ACC_BITS-1:0] acc;
  logic [CNT_BITS-1:0] bit_cnt;
  logic [3:0]          ch;

  logic in_take;
  logic out_free;
  logic load_out;
  logic end_ok;
  logic [VAL_BITS-1:0] ch_value;

  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign wr_addr  = in_frame ? IDX_BITS'(byte_index + 5'd1) : '0;
  assign mem_we   = in_take && (in_frame || (rx_byte == START_BYTE));
  // the arriving byte closes the frame
  assign end_ok   = in_frame && (byte_index == IDX_BITS'(END_IDX - 5'd1))
                    && (rx_byte == END_BYTE);

  // channels 0 to 3 carry the middle value on lost or failsafe
  assign ch_value = ((ch < SubstCh) && (status != LINK_OK)) ?
                    middle_value : acc[VAL_BITS-1:0];

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RX;
    end else begin
      state <= state_next;
    end
  end

  // next state and control
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    load_out   = 1'b0;
    unique case (state)
      S_RX: begin
        in_stall = 1'b0;
        if (in_take && end_ok) begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        state_next = S_MERGE;
      end
      S_MERGE: begin
        // enough bits for a channel once the byte is in
        if (bit_cnt >= MergeNeed) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_FETCH;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          // at most 7 bits remain, so another byte is always needed
          state_next = (ch == LastCh) ? S_RX : S_FETCH;
        end
      end
      default: begin
        state_next = S_RX;
      end
    endcase
  end

  // frame store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_store[wr_addr] <= rx_byte;
    end
    if (state == S_FETCH) begin
      rd_data <= frame_store[rd_addr];
    end
  end

  // byte collection, frame framing, flag byte and middle value register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame     <= 1'b0;
      byte_index   <= '0;
      status       <= LINK_OK;
      middle_value <= MIDDLE_RESET;
    end else begin
      if (cfg_we) begin
        middle_value <= cfg_wdata;
      end
      if (in_take) begin
        if (!in_frame) begin
          if (rx_byte == START_BYTE) begin
            in_frame   <= 1'b1;
            byte_index <= '0;
          end
        end else begin
          byte_index <= wr_addr;
          if (wr_addr == FLAG_IDX) begin
            // lost wins over failsafe
            if (rx_byte[LOST_BIT]) begin
              status <= LINK_LOST;
            end else if (rx_byte[FAILSAFE_BIT]) begin
              status <= LINK_FAILSAFE;
            end else begin
              status <= LINK_OK;
            end
          end
          if (wr_addr == END_IDX) begin
            in_frame <= 1'b0;
          end
        end
      end
    end
  end

  // unpack: little-endian bit stream, one byte per fetch/merge pass
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_addr <= FIRST_DATA_IDX;
      bit_cnt <= '0;
      ch      <= '0;
      acc     <= '0;
    end else begin
      if (state == S_RX && in_take && end_ok) begin
        rd_addr <= FIRST_DATA_IDX;
        bit_cnt <= '0;
        ch      <= '0;
        acc     <= '0;
      end
      if (state == S_FETCH) begin
        rd_addr <= IDX_BITS'(rd_addr + 5'd1);
      end
      if (state == S_MERGE) begin
        acc     <= acc | (ACC_BITS'(rd_data) << bit_cnt);
        bit_cnt <= CNT_BITS'(bit_cnt + 5'd8);
      end
      if (load_out) begin
        acc     <= acc >> VAL_BITS;
        bit_cnt <= CNT_BITS'(bit_cnt - ValBits);
        ch      <= 4'(ch + 4'd1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      channel     <= ch;
      value       <= ch_value;
      link_status <= status;
      last        <= (ch == LastCh);
    end
  end

  // never fetch past the last packed byte
  a_rd_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |-> (rd_addr <= FLAG_IDX - 5'd1))
    else $error("packed byte read out of range");

  // a fetch only happens while short of a whole channel
  a_cnt_fetch: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |-> (bit_cnt < ValBits))
    else $error("fetch with a full channel pending");

  // unpacking and collecting never overlap
  a_no_frame: assert property (@(posedge clk) disable iff (rst)
    (state != S_RX) |-> !in_frame)
    else $error("frame open during unpack");

  // a non-final channel word means more of the frame is still to come
  a_more: assert property (@(posedge clk) disable iff (rst)
    (load_out && (ch != LastCh)) |=> (state != S_RX))
    else $error("unpack ended before the last channel");

endmodule
